/* src/mie_pkg.sv */
`timescale 1ns / 1ps

package mie_pkg;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // start a new item and begin reducing value by modulus
      logic step;     // one restoring division step
      logic set_r1;   // take the reduction remainder as the second remainder
      logic start;    // begin dividing the first remainder by the second
      logic update;   // shift the remainder and coefficient pairs
      logic lift;     // add the modulus to a negative coefficient
      logic emit;     // move the result into the output register
   } mie_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cnt_last;
      logic r1_zero;
      logic mod_zero;
   } mie_stat_type;

endpackage

/* src/mie_dpath.sv */
`timescale 1ns / 1ps

module mie_dpath
   import mie_pkg::*;
#(
   parameter int W = 32
) (
   input  logic          clock,
   input  mie_cmd_type   cmd,
   input  logic [W-1:0]  modulus,
   input  logic [W-1:0]  value,
   output mie_stat_type  stat,
   output logic [W-1:0]  inverse,
   output logic [W-1:0]  gcd_result
);

   localparam int CW = $clog2(W);

   // Remainder pair, coefficient pair (two's complement, one extra bit).
   logic [W-1:0]  r0_ff, r0_in, r1_ff, r1_in;
   logic [W:0]    s0_ff, s0_in, s1_ff, s1_in;
   // Shared restoring divider and the running product quotient times s1.
   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [W:0]    acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [W:0]    rem_sh, rem_diff;
   logic          q_bit;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[W-1]};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      q_bit    = (rem_sh >= {1'b0, dvs_ff});
   end

   always_comb begin
      r0_in  = r0_ff;
      r1_in  = r1_ff;
      s0_in  = s0_ff;
      s1_in  = s1_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         r0_in  = modulus;
         r1_in  = '0;
         s0_in  = '0;
         s1_in  = {{W{1'b0}}, 1'b1};
         rem_in = '0;
         quo_in = value;
         dvs_in = modulus;
         acc_in = '0;
         cnt_in = '0;
      end
      if (cmd.step) begin
         rem_in = q_bit ? rem_diff[W-1:0] : rem_sh[W-1:0];
         quo_in = {quo_ff[W-2:0], q_bit};
         // Product is built MSB first alongside the quotient bits; it wraps
         // modulo 2^(W+1), which is exact for the coefficient difference.
         acc_in = {acc_ff[W-1:0], 1'b0} + (q_bit ? s1_ff : '0);
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.set_r1) begin
         r1_in = rem_ff;
      end
      if (cmd.start) begin
         rem_in = '0;
         quo_in = r0_ff;
         dvs_in = r1_ff;
         acc_in = '0;
         cnt_in = '0;
      end
      if (cmd.update) begin
         r0_in = r1_ff;
         r1_in = rem_ff;
         s0_in = s1_ff;
         s1_in = s0_ff - acc_ff;
      end
      if (cmd.lift && s0_ff[W]) begin
         s0_in = s0_ff + {1'b0, modulus};
      end
   end

   always_ff @(posedge clock) begin
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      s0_ff  <= s0_in;
      s1_ff  <= s1_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      stat.cnt_last = (cnt_ff == CW'(W - 1));
      stat.r1_zero  = (r1_ff == '0);
      stat.mod_zero = (modulus == '0);
   end

   assign inverse    = s0_ff[W-1:0];
   assign gcd_result = r0_ff;

endmodule

/* src/mie_ctrl.sv */
`timescale 1ns / 1ps

module mie_ctrl
   import mie_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         out_free,
   input  mie_stat_type stat,
   output mie_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RED  = 3'd1;
   localparam logic [2:0] ST_SET  = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_UPD  = 3'd5;
   localparam logic [2:0] ST_LIFT = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               // A zero modulus is answered with zeros, which load leaves.
               state_in = stat.mod_zero ? ST_FIN : ST_RED;
            end
         end
         ST_RED: begin
            cmd.step = 1'b1;
            if (stat.cnt_last) begin
               state_in = ST_SET;
            end
         end
         ST_SET: begin
            cmd.set_r1 = 1'b1;
            state_in   = ST_CHK;
         end
         ST_CHK: begin
            if (stat.r1_zero) begin
               state_in = ST_LIFT;
            end else begin
               cmd.start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (stat.cnt_last) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_CHK;
         end
         ST_LIFT: begin
            cmd.lift = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/modular_inverse_ext_euclid.sv */
`timescale 1ns / 1ps

// Channel   Direction  Ports                          Contents
// req       in         req_tvalid/tready/tdata[31:0]  value
// rsp       out        rsp_tvalid/tready/tdata[63:0]  inverse, gcd_result
// csr       in         csr_we, csr_wdata[31:0]        modulus (reset 2)
//
// An item reduces value by the modulus and then runs k Euclid iterations, where k is up
// to about 46 at W = 32 and W is OPERAND_WIDTH; a zero modulus skips both.
// The single restoring divider, one quotient bit per cycle, is shared by the initial
// reduction and every iteration. Reset is synchronous, active high, sets the modulus to 2
// and empties the result register. A stalled result holds in its register; the next item
// is accepted and parks in its final state until it frees.

module modular_inverse_ext_euclid
   import mie_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Input items: [31:0] value.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // Result items: [31:0] inverse, [63:32] gcd_result.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // Modulus register write.
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int W = OPERAND_WIDTH;

   logic [31:0]  modulus_ff;
   logic [W-1:0] mod_w, val_w, inv_w, gcd_w;
   logic [31:0]  inv_ext, gcd_ext;
   logic         rsp_valid_ff;
   logic [63:0]  rsp_data_ff;
   logic         out_free;

   mie_cmd_type  cmd;
   mie_stat_type stat;

   // The user must write the modulus register only between items; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= 32'd2;
      end else if (csr_we) begin
         modulus_ff <= csr_wdata;
      end
   end

   // Operands are taken in their low W bits; results are masked back to W
   // bits and then fitted to the 32-bit fields.
   generate
      if (W <= 32) begin : g_narrow
         assign mod_w   = modulus_ff[W-1:0];
         assign val_w   = req_tdata[W-1:0];
         assign inv_ext = 32'(inv_w);
         assign gcd_ext = 32'(gcd_w);
      end else begin : g_wide
         assign mod_w   = {{(W - 32){1'b0}}, modulus_ff};
         assign val_w   = {{(W - 32){1'b0}}, req_tdata};
         assign inv_ext = inv_w[31:0];
         assign gcd_ext = gcd_w[31:0];
      end
   endgenerate

   mie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .stat      (stat),
      .cmd       (cmd)
   );

   mie_dpath #(
      .W (W)
   ) u_dpath (
      .clock      (clock),
      .cmd        (cmd),
      .modulus    (mod_w),
      .value      (val_w),
      .stat       (stat),
      .inverse    (inv_w),
      .gcd_result (gcd_w)
   );

   // The output register is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {gcd_ext, inv_ext};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A result is never written over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while occupied");

   // Once an item is taken the block is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while an item is in progress");

   // With a nonzero modulus the gcd is nonzero and the lifted coefficient
   // lies below the modulus.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && (mod_w != '0)) |-> ((gcd_w != '0) && (inv_w < mod_w)))
      else $error("result out of range for the modulus");

endmodule
